// ===== hw/rtl/sat_pkg.sv =====
// Section address translator: shared constants, codes and types.
// Used by the channel interfaces and every module of the block.
package sat_pkg;

    localparam int ACT_W      = 3;
    localparam int EIDX_W     = 6;
    localparam int ADDR_W     = 32;
    localparam int RES_W      = 64;
    localparam int STAT_W     = 2;
    localparam int CNT_CFG_W  = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    localparam int DEF_MAX_SECTIONS = 64;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RVA2OFF = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OFF2RVA = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RVA2VA  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STAT_W-1:0] ST_HEADER = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOMAP  = 2'd2;
    localparam logic [STAT_W-1:0] ST_VIRT   = 2'd3;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_BASE_VA       = 2'd0;
    localparam logic [1:0] REG_HEADER_SIZE   = 2'd1;
    localparam logic [1:0] REG_SECTION_COUNT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] vsize;
        logic [ADDR_W-1:0] rsize;
        logic [ADDR_W-1:0] rptr;
    } sect_t;

    typedef struct packed {
        logic [RES_W-1:0]     base_va;
        logic [ADDR_W-1:0]    header_size;
        logic [CNT_CFG_W-1:0] section_count;
    } cfg_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RES_W-1:0]  addr;
        logic [EIDX_W-1:0] hit;
    } res_t;

endpackage

// ===== hw/rtl/sat_if.sv =====
// Section address translator: valid/ready channel interfaces for query
// and result words. Depends on sat_pkg.
interface sat_in_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::ACT_W-1:0]    action;
    logic [sat_pkg::EIDX_W-1:0]   entry_index;
    logic [sat_pkg::ADDR_W-1:0]   query_addr;
    logic [sat_pkg::ADDR_W-1:0]   sec_virt_addr;
    logic [sat_pkg::ADDR_W-1:0]   sec_virt_size;
    logic [sat_pkg::ADDR_W-1:0]   sec_raw_size;
    logic [sat_pkg::ADDR_W-1:0]   sec_raw_ptr;

    modport source (
        output valid, action, entry_index, query_addr,
               sec_virt_addr, sec_virt_size, sec_raw_size, sec_raw_ptr,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, query_addr,
               sec_virt_addr, sec_virt_size, sec_raw_size, sec_raw_ptr,
        output ready
    );
endinterface

interface sat_out_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::STAT_W-1:0]   status;
    logic [sat_pkg::RES_W-1:0]    result_addr;
    logic [sat_pkg::EIDX_W-1:0]   hit_index;

    modport source (
        output valid, status, result_addr, hit_index,
        input  ready
    );
    modport sink (
        input  valid, status, result_addr, hit_index,
        output ready
    );
endinterface

// ===== hw/rtl/section_address_translator_top.sv =====
// Loads, rva-to-va and unknown actions go from the engine straight to the output word;
// queries scan up to min(section_count, MAX_SECTIONS) entries one per cycle, stop at
// the first match, then compute and register the result. One word at a time: the next
// query is taken only after the last result has left the engine, which a stalled sink holds.
// Reset clears control state and config registers; table contents stay undefined.
// Depends on sat_pkg, sat_if, sat_cfg, sat_engine.
module section_address_translator_top #(
    parameter int MAX_SECTIONS = sat_pkg::DEF_MAX_SECTIONS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sat_in_if.sink                         in_ch,
    sat_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sat_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sat_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sat_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import sat_pkg::*;

    cfg_t cfg;
    res_t res;
    logic res_valid;
    logic res_ready;

    logic out_valid_reg, out_valid_next;
    res_t out_word_reg;

    sat_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sat_engine #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output word register decouples the engine from the result sink
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
            out_valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_word_reg <= res;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_word_reg.status;
    assign out_ch.result_addr = out_word_reg.addr;
    assign out_ch.hit_index   = out_word_reg.hit;

endmodule

// ===== hw/rtl/sat_cfg.sv =====
// Section address translator: APB configuration registers.
// Depends on sat_pkg.
module sat_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sat_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sat_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sat_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sat_pkg::cfg_t                  cfg
);
    import sat_pkg::*;

    logic [RES_W-1:0]     base_va_reg;
    logic [ADDR_W-1:0]    header_size_reg;
    logic [CNT_CFG_W-1:0] section_count_reg;
    logic                 wr_en;
    logic [1:0]           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_va_reg       <= '0;
            header_size_reg   <= '0;
            section_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BASE_VA:       base_va_reg       <= pwdata;
                REG_HEADER_SIZE:   header_size_reg   <= pwdata[ADDR_W-1:0];
                REG_SECTION_COUNT: section_count_reg <= pwdata[CNT_CFG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BASE_VA:       prdata = base_va_reg;
            REG_HEADER_SIZE:   prdata = CFG_DATA_W'(header_size_reg);
            REG_SECTION_COUNT: prdata = CFG_DATA_W'(section_count_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.base_va       = base_va_reg;
    assign cfg.header_size   = header_size_reg;
    assign cfg.section_count = section_count_reg;

endmodule

// ===== hw/rtl/sat_engine.sv =====
// Section address translator: section table memory and scan sequencer.
// One compare/add unit checks one table entry per cycle. Depends on sat_pkg, sat_if.
module sat_engine #(
    parameter int MAX_SECTIONS = sat_pkg::DEF_MAX_SECTIONS
) (
    input  logic           clk,
    input  logic           rst_n,
    sat_in_if.sink         in_ch,
    input  sat_pkg::cfg_t  cfg,
    output logic           res_valid,
    input  logic           res_ready,
    output sat_pkg::res_t  res
);
    import sat_pkg::*;

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int EXT_W = IDX_W + EIDX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    sect_t mem [MAX_SECTIONS];

    logic [2:0]        state_reg,   state_next;
    logic [ACT_W-1:0]  act_reg,     act_next;
    logic [ADDR_W-1:0] q_reg,       q_next;
    logic [CNT_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [CNT_W-1:0]  limit_reg,   limit_next;
    logic              rd_vld_reg,  rd_vld_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    sect_t             rdata_reg;
    sect_t             hit_ent_reg, hit_ent_next;
    logic [ADDR_W-1:0] off_reg,     off_next;
    res_t              res_reg,     res_next;

    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [EXT_W-1:0]  eidx_ext;
    logic [EXT_W-1:0]  hit_ext;
    logic [EIDX_W-1:0] hit_six;
    logic [CNT_W-1:0]  limit_cfg;
    logic              accept;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] vend;
    logic [ADDR_W-1:0] rend;
    logic              match;
    logic [ADDR_W-1:0] fin_sum;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign res_valid   = (state_reg == S_DONE);
    assign res         = res_reg;

    assign eidx_ext = EXT_W'(in_ch.entry_index);
    assign wr_addr  = eidx_ext[IDX_W-1:0];
    assign wr_en    = accept && (in_ch.action == ACT_LOAD)
                      && (eidx_ext < EXT_W'(MAX_SECTIONS));

    assign hit_ext  = EXT_W'(hit_idx_reg);
    assign hit_six  = hit_ext[EIDX_W-1:0];

    assign limit_cfg = (32'(cfg.section_count) < 32'(MAX_SECTIONS))
                       ? CNT_W'(cfg.section_count) : CNT_W'(MAX_SECTIONS);

    // range check of the entry read last cycle; a wrapped end matches nothing
    assign span = (rdata_reg.vsize > rdata_reg.rsize) ? rdata_reg.vsize : rdata_reg.rsize;
    assign vend = rdata_reg.va + span;
    assign rend = rdata_reg.rptr + rdata_reg.rsize;
    assign match = (act_reg == ACT_OFF2RVA)
                   ? (q_reg >= rdata_reg.rptr && q_reg < rend)
                   : (q_reg >= rdata_reg.va && q_reg < vend);

    // translated address wraps at 32 bits
    assign fin_sum = ((act_reg == ACT_OFF2RVA) ? hit_ent_reg.va : hit_ent_reg.rptr) + off_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{va: in_ch.sec_virt_addr, vsize: in_ch.sec_virt_size,
                              rsize: in_ch.sec_raw_size, rptr: in_ch.sec_raw_ptr};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        q_next       = q_reg;
        rd_ptr_next  = rd_ptr_reg;
        limit_next   = limit_reg;
        rd_vld_next  = rd_vld_reg;
        chk_idx_next = chk_idx_reg;
        hit_idx_next = hit_idx_reg;
        hit_ent_next = hit_ent_reg;
        off_next     = off_reg;
        res_next     = res_reg;
        rd_en        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next = in_ch.action;
                    q_next   = in_ch.query_addr;
                    case (in_ch.action)
                        ACT_LOAD:
                        begin
                            res_next   = '{status: ST_HIT, addr: '0, hit: '0};
                            state_next = S_DONE;
                        end
                        ACT_RVA2OFF, ACT_OFF2RVA, ACT_FIND:
                        begin
                            rd_ptr_next = '0;
                            rd_vld_next = 1'b0;
                            limit_next  = limit_cfg;
                            state_next  = S_SCAN;
                        end
                        ACT_RVA2VA:
                        begin
                            res_next = '{status: ST_HIT,
                                         addr: cfg.base_va + RES_W'(in_ch.query_addr),
                                         hit: '0};
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            res_next   = '{status: ST_NOMAP, addr: '0, hit: '0};
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg && match)
                begin
                    hit_ent_next = rdata_reg;
                    hit_idx_next = chk_idx_reg;
                    rd_vld_next  = 1'b0;
                    state_next   = S_CALC;
                end
                else if (rd_ptr_reg < limit_reg)
                begin
                    rd_en        = 1'b1;
                    chk_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_vld_next  = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    // no section matched: headers map to themselves, except for find
                    rd_vld_next = 1'b0;
                    if (act_reg != ACT_FIND && q_reg < cfg.header_size)
                        res_next = '{status: ST_HEADER, addr: RES_W'(q_reg), hit: '0};
                    else
                        res_next = '{status: ST_NOMAP, addr: '0, hit: '0};
                    state_next = S_DONE;
                end
            end
            S_CALC:
            begin
                off_next   = q_reg - ((act_reg == ACT_OFF2RVA) ? hit_ent_reg.rptr
                                                               : hit_ent_reg.va);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                case (act_reg)
                    ACT_RVA2OFF:
                    begin
                        if (off_reg < hit_ent_reg.rsize)
                            res_next = '{status: ST_HIT,
                                         addr: RES_W'(fin_sum),
                                         hit: hit_six};
                        else
                            res_next = '{status: ST_VIRT, addr: '0, hit: hit_six};
                    end
                    ACT_OFF2RVA:
                        res_next = '{status: ST_HIT,
                                     addr: RES_W'(fin_sum),
                                     hit: hit_six};
                    default:
                        res_next = '{status: ST_HIT, addr: RES_W'(hit_ent_reg.va),
                                     hit: hit_six};
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        q_reg       <= q_next;
        rd_ptr_reg  <= rd_ptr_next;
        limit_reg   <= limit_next;
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_ent_reg <= hit_ent_next;
        off_reg     <= off_next;
        res_reg     <= res_next;
    end

endmodule
